### rtl/dlsl_pkg.sv
// Shared constants, operation codes and controller/datapath interface types.
package dlsl_pkg;

    localparam int POOL_SLOTS_DEF = 16;
    localparam int WORD_BITS      = 16;
    localparam int KIND_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int POS_W          = 4;
    localparam int CFG_W          = 5;

    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;

    localparam logic [KIND_W-1:0] KIND_INS_AFTER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INS_BEFORE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic ld_op;
        logic do_check;
        logic do_scan;
        logic do_link;
        logic ld_out;
    } cmd_t;

    typedef struct packed {
        logic start_scan;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } sts_t;

endpackage

### rtl/dlsl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dlsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dlsl_ctrl.sv
// Controller state machine that sequences check, free-slot scan, relink and result.
module dlsl_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dlsl_pkg::sts_t sts,
    output dlsl_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_LINK  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.ld_op  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.do_check = 1'b1;
                state_next   = sts.start_scan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                cmd.do_scan = 1'b1;
                priority if (sts.scan_hit) begin
                    state_next = ST_LINK;
                end else if (sts.scan_end) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_LINK: begin
                cmd.do_link = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/dlsl_dp.sv
// Datapath: link and valid-word memories, head and tail, free-slot scan and result register.
module dlsl_dp #(
    parameter int POOL_SLOTS = dlsl_pkg::POOL_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dlsl_pkg::cmd_t                cmd,
    output dlsl_pkg::sts_t                sts,
    input  logic [dlsl_pkg::KIND_W-1:0]   s_kind,
    input  logic                          s_has_position,
    input  logic [dlsl_pkg::POS_W-1:0]    s_position,
    input  logic                          cfg_valid,
    input  logic [dlsl_pkg::CFG_W-1:0]    cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dlsl_pkg::POS_W-1:0]    m_slot,
    output logic [dlsl_pkg::STATUS_W-1:0] m_status,
    output logic [dlsl_pkg::POS_W-1:0]    m_head_slot,
    output logic [dlsl_pkg::POS_W-1:0]    m_tail_slot,
    output logic                          m_list_empty
);

    localparam int SW = $clog2(POOL_SLOTS);
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam int WB = dlsl_pkg::WORD_BITS;
    localparam int BW = $clog2(WB);
    localparam int NW = (POOL_SLOTS + WB - 1) / WB;
    localparam int WW = (NW > 1) ? $clog2(NW) : 1;
    localparam int GW = WW + BW + 1;
    localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);

    // Configuration register.
    logic [dlsl_pkg::CFG_W-1:0] slots_in_use_reg;

    // Operation registers.
    logic [dlsl_pkg::KIND_W-1:0] kind_reg;
    logic                        has_pos_reg;
    logic                        in_pool_reg;
    logic [GW-1:0]               pos_g_reg;
    logic [LW-1:0]               anchor_reg;

    // List state.
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] tail_reg, tail_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] n_reg, n_next;
    logic [LW-1:0] x_reg;
    logic [WW-1:0] scan_word_reg, scan_word_next;
    logic [NW-1:0] wflag_reg, wflag_next;
    logic          vflag_reg;

    // Result.
    logic [dlsl_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [LW-1:0]                 res_slot_reg, res_slot_next;
    logic                          m_valid_reg;
    logic [dlsl_pkg::POS_W-1:0]    m_slot_reg, m_head_reg, m_tail_reg;
    logic [dlsl_pkg::STATUS_W-1:0] m_status_reg;
    logic                          m_empty_reg;

    // Memory ports.
    logic          nx_we, pv_we, v_we;
    logic [SW-1:0] nx_waddr, pv_waddr;
    logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;
    logic [SW-1:0] link_raddr;
    logic [WW-1:0] v_waddr, v_raddr;
    logic [WB-1:0] v_wdata, v_rdata;

    // Combinational helpers.
    logic [GW-1:0] pos_in_g;
    logic [WB-1:0] vword;
    logic [WW-1:0] pos_word;
    logic [BW-1:0] pos_bit;
    logic          pos_valid;
    logic          is_insert;
    logic [GW-1:0] lim;
    logic [GW-1:0] base;
    logic [GW-1:0] base_next;
    logic [WB-1:0] mask;
    logic [WB-1:0] free_bits;
    logic [WB-1:0] first_free;
    logic [BW-1:0] hit_bit;
    logic          hit;
    logic [GW-1:0] x_g;

    assign pos_in_g  = GW'(s_position);
    assign vword     = v_rdata & {WB{vflag_reg}};
    assign pos_word  = pos_g_reg[BW+WW-1:BW];
    assign pos_bit   = pos_g_reg[BW-1:0];
    assign pos_valid = has_pos_reg & in_pool_reg & vword[pos_bit];
    assign is_insert = (kind_reg == dlsl_pkg::KIND_INS_AFTER) ||
                       (kind_reg == dlsl_pkg::KIND_INS_BEFORE);

    assign lim = (GW'(slots_in_use_reg) > GW'(POOL_SLOTS)) ? GW'(POOL_SLOTS)
                                                            : GW'(slots_in_use_reg);
    assign base      = GW'(scan_word_reg) << BW;
    assign base_next = (GW'(scan_word_reg) + GW'(1)) << BW;

    // Lowest free slot of the current word that lies below the allocation limit.
    always_comb begin
        mask    = '0;
        hit_bit = '0;
        for (int b = 0; b < WB; b++) begin
            mask[b] = (base + GW'(b)) < lim;
        end
        free_bits  = ~vword & mask;
        first_free = free_bits & (~free_bits + WB'(1));
        for (int b = 0; b < WB; b++) begin
            if (first_free[b]) begin
                hit_bit = hit_bit | BW'(b);
            end
        end
    end

    assign hit = |free_bits;
    assign x_g = base + GW'(hit_bit);

    assign sts.start_scan = is_insert && !(has_pos_reg && !pos_valid);
    assign sts.scan_hit   = hit;
    assign sts.scan_end   = !hit && (base_next >= lim);
    assign sts.out_free   = !m_valid_reg || m_ready;

    // Memory address and write selection.
    assign link_raddr = SW'(s_position);
    assign v_raddr    = cmd.ld_op ? pos_in_g[BW+WW-1:BW] : scan_word_next;

    always_comb begin
        nx_we    = 1'b0;
        nx_waddr = '0;
        nx_wdata = '0;
        pv_we    = 1'b0;
        pv_waddr = '0;
        pv_wdata = '0;
        v_we     = 1'b0;
        v_waddr  = '0;
        v_wdata  = '0;
        priority if (cmd.do_check && kind_reg == dlsl_pkg::KIND_DELETE && pos_valid) begin
            // Unlink the deleted slot from its neighbors and free it.
            nx_we    = (pv_rdata != NIL);
            nx_waddr = SW'(pv_rdata);
            nx_wdata = nx_rdata;
            pv_we    = (nx_rdata != NIL);
            pv_waddr = SW'(nx_rdata);
            pv_wdata = pv_rdata;
            v_we     = 1'b1;
            v_waddr  = pos_word;
            v_wdata  = vword & ~(WB'(1) << pos_bit);
        end else if (cmd.do_scan && hit) begin
            nx_we    = 1'b1;
            nx_waddr = SW'(x_g);
            nx_wdata = n_reg;
            pv_we    = 1'b1;
            pv_waddr = SW'(x_g);
            pv_wdata = p_reg;
            v_we     = 1'b1;
            v_waddr  = scan_word_reg;
            v_wdata  = vword | first_free;
        end else if (cmd.do_link) begin
            nx_we    = (p_reg != NIL);
            nx_waddr = SW'(p_reg);
            nx_wdata = x_reg;
            pv_we    = (n_reg != NIL);
            pv_waddr = SW'(n_reg);
            pv_wdata = x_reg;
        end else begin
            nx_we = 1'b0;
        end
    end

    always_comb begin
        wflag_next = wflag_reg;
        if (v_we) begin
            wflag_next[v_waddr] = 1'b1;
        end
    end

    // Next-state logic for list pointers, scan position and result.
    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        scan_word_next  = scan_word_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        if (cmd.do_check) begin
            scan_word_next  = '0;
            res_slot_next   = '0;
            res_status_next = dlsl_pkg::STAT_OK;
            unique case (kind_reg)
                dlsl_pkg::KIND_DELETE: begin
                    if (!pos_valid) begin
                        res_status_next = dlsl_pkg::STAT_BAD;
                    end else begin
                        if (head_reg == anchor_reg) begin
                            head_next = nx_rdata;
                        end
                        if (tail_reg == anchor_reg) begin
                            tail_next = pv_rdata;
                        end
                    end
                end
                dlsl_pkg::KIND_INS_AFTER: begin
                    if (has_pos_reg && !pos_valid) begin
                        res_status_next = dlsl_pkg::STAT_BAD;
                    end
                    p_next = anchor_reg;
                    n_next = has_pos_reg ? nx_rdata : head_reg;
                end
                dlsl_pkg::KIND_INS_BEFORE: begin
                    if (has_pos_reg && !pos_valid) begin
                        res_status_next = dlsl_pkg::STAT_BAD;
                    end
                    n_next = anchor_reg;
                    p_next = has_pos_reg ? pv_rdata : tail_reg;
                end
                default: begin
                    res_status_next = dlsl_pkg::STAT_OK;
                end
            endcase
        end
        if (cmd.do_scan) begin
            priority if (hit) begin
                res_slot_next = LW'(x_g);
            end else if (base_next >= lim) begin
                res_status_next = dlsl_pkg::STAT_FULL;
            end else begin
                scan_word_next = scan_word_reg + WW'(1);
            end
        end
        if (cmd.do_link) begin
            if (kind_reg == dlsl_pkg::KIND_INS_AFTER) begin
                if (anchor_reg == tail_reg) begin
                    tail_next = x_reg;
                end
                if (head_reg == NIL || !has_pos_reg) begin
                    head_next = x_reg;
                end
            end else begin
                if (anchor_reg == head_reg) begin
                    head_next = x_reg;
                end
                if (tail_reg == NIL || !has_pos_reg) begin
                    tail_next = x_reg;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= dlsl_pkg::SLOTS_IN_USE_RST;
            head_reg         <= NIL;
            tail_reg         <= NIL;
            wflag_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                slots_in_use_reg <= cfg_data;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            wflag_reg <= wflag_next;
            if (cmd.ld_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        vflag_reg      <= wflag_reg[v_raddr];
        p_reg          <= p_next;
        n_reg          <= n_next;
        scan_word_reg  <= scan_word_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (cmd.ld_op) begin
            kind_reg    <= s_kind;
            has_pos_reg <= s_has_position;
            in_pool_reg <= (32'(s_position) < POOL_SLOTS);
            pos_g_reg   <= pos_in_g;
            anchor_reg  <= s_has_position ? LW'(s_position) : NIL;
        end
        if (cmd.do_scan && hit) begin
            x_reg <= LW'(x_g);
        end
        if (cmd.ld_out) begin
            m_slot_reg   <= dlsl_pkg::POS_W'(res_slot_reg);
            m_status_reg <= res_status_reg;
            m_head_reg   <= (head_reg == NIL) ? '0 : dlsl_pkg::POS_W'(head_reg);
            m_tail_reg   <= (tail_reg == NIL) ? '0 : dlsl_pkg::POS_W'(tail_reg);
            m_empty_reg  <= (head_reg == NIL);
        end
    end

    dlsl_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_SLOTS)
    ) u_next_ram (
        .clk   (aclk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (link_raddr),
        .rdata (nx_rdata)
    );

    dlsl_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_SLOTS)
    ) u_prev_ram (
        .clk   (aclk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (link_raddr),
        .rdata (pv_rdata)
    );

    // Slot valid bits, one word of WORD_BITS slots per entry. A word never
    // written reads as all free.
    dlsl_ram #(
        .WIDTH (WB),
        .DEPTH (NW)
    ) u_valid_ram (
        .clk   (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    assign m_valid      = m_valid_reg;
    assign m_slot       = m_slot_reg;
    assign m_status     = m_status_reg;
    assign m_head_slot  = m_head_reg;
    assign m_tail_slot  = m_tail_reg;
    assign m_list_empty = m_empty_reg;

endmodule

### rtl/doubly_linked_slot_list_unit.sv
// Top level of the doubly linked slot list unit: controller, datapath and config port.
//
// Keeps a doubly linked list over a pool of POOL_SLOTS slots. Each input transaction
// is an insert-after, insert-before or delete, and gives exactly one result transaction
// with the allocated slot, a status and the head and tail after the operation. One
// operation is handled at a time. A delete, a rejected operation or an unknown kind
// goes from acceptance to the next possible acceptance through a read of the link
// and valid memories, a check-and-write step and a result load. An insert that links
// a slot goes through the read, the check, a scan of the 16-slot valid words for the
// lowest free slot (a single word for a pool of up to 16 slots), whose last step
// also writes the new slot's own links, a step to link the neighbors, since each
// link memory has a single write port, and the result load. An insert that meets a
// full pool skips the link step. A new transaction is accepted while the previous
// result still waits in the output register; the result load waits for that
// register to drain. The slots_in_use register is written through the cfg channel,
// which is always ready, and resets to 16.
module doubly_linked_slot_list_unit #(
    parameter int POOL_SLOTS = dlsl_pkg::POOL_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dlsl_pkg::KIND_W-1:0]   s_kind,
    input  logic                          s_has_position,
    input  logic [dlsl_pkg::POS_W-1:0]    s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dlsl_pkg::POS_W-1:0]    m_slot,
    output logic [dlsl_pkg::STATUS_W-1:0] m_status,
    output logic [dlsl_pkg::POS_W-1:0]    m_head_slot,
    output logic [dlsl_pkg::POS_W-1:0]    m_tail_slot,
    output logic                          m_list_empty,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dlsl_pkg::CFG_W-1:0]    cfg_data
);

    dlsl_pkg::cmd_t cmd;
    dlsl_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    dlsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dlsl_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_kind         (s_kind),
        .s_has_position (s_has_position),
        .s_position     (s_position),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot         (m_slot),
        .m_status       (m_status),
        .m_head_slot    (m_head_slot),
        .m_tail_slot    (m_tail_slot),
        .m_list_empty   (m_list_empty)
    );

endmodule

### bench/list_checker.sv
// Checker for the slot list unit: predicts every result and compares it with the block.
module list_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [dlsl_pkg::KIND_W-1:0]           s_kind,
    input  logic                                  s_has_position,
    input  logic [dlsl_pkg::POS_W-1:0]            s_position,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [dlsl_pkg::POS_W-1:0]            m_slot,
    input  logic [dlsl_pkg::STATUS_W-1:0]         m_status,
    input  logic [dlsl_pkg::POS_W-1:0]            m_head_slot,
    input  logic [dlsl_pkg::POS_W-1:0]            m_tail_slot,
    input  logic                                  m_list_empty,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [dlsl_pkg::CFG_W-1:0]            cfg_data,
    output int                                    mismatches,
    output int                                    outstanding,
    output logic [dlsl_pkg::POOL_SLOTS_DEF-1:0]   occupied,
    output int                                    results_checked,
    output int                                    inserts_linked,
    output int                                    full_reports,
    output int                                    rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL   = dlsl_pkg::POOL_SLOTS_DEF;
    localparam int LINK_W = $clog2(POOL) + 1;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL);

    typedef logic [LINK_W-1:0] link_t;

    typedef struct packed {
        logic [dlsl_pkg::POS_W-1:0]    slot;
        logic [dlsl_pkg::STATUS_W-1:0] status;
        logic [dlsl_pkg::POS_W-1:0]    head;
        logic [dlsl_pkg::POS_W-1:0]    tail;
        logic                          empty;
    } list_result_t;

    logic [dlsl_pkg::CFG_W-1:0] slots_in_use;
    logic [POOL-1:0]            slot_valid;
    link_t                      prev_link [POOL];
    link_t                      next_link [POOL];
    link_t                      head_link;
    link_t                      tail_link;
    list_result_t               expected_results [$];
    list_result_t               want;

    function automatic list_result_t apply_list_op(logic [dlsl_pkg::KIND_W-1:0] kind,
                                                   logic has_pos,
                                                   logic [dlsl_pkg::POS_W-1:0] pos);
        list_result_t r;
        link_t        anchor;
        link_t        p;
        link_t        n;
        link_t        x;
        logic         was_empty;
        int           limit;
        int           i;
        r.slot   = '0;
        r.status = dlsl_pkg::STAT_OK;
        x        = NIL;
        if (kind == dlsl_pkg::KIND_DELETE) begin
            if (!has_pos || !slot_valid[pos]) begin
                r.status = dlsl_pkg::STAT_BAD;
            end else begin
                p = prev_link[pos];
                n = next_link[pos];
                slot_valid[pos] = 1'b0;
                if (p != NIL) next_link[p] = n;
                if (n != NIL) prev_link[n] = p;
                if (head_link == link_t'(pos)) head_link = n;
                if (tail_link == link_t'(pos)) tail_link = p;
            end
        end else if (kind == dlsl_pkg::KIND_INS_AFTER ||
                     kind == dlsl_pkg::KIND_INS_BEFORE) begin
            limit  = (int'(slots_in_use) > POOL) ? POOL : int'(slots_in_use);
            anchor = has_pos ? link_t'(pos) : NIL;
            if (has_pos && !slot_valid[pos]) begin
                r.status = dlsl_pkg::STAT_BAD;
            end else begin
                for (i = 0; i < limit; i++) begin
                    if (!slot_valid[i] && x == NIL) x = link_t'(i);
                end
                if (x == NIL) begin
                    r.status = dlsl_pkg::STAT_FULL;
                end else begin
                    if (kind == dlsl_pkg::KIND_INS_AFTER) begin
                        p         = anchor;
                        n         = has_pos ? next_link[pos] : head_link;
                        was_empty = (head_link == NIL);
                    end else begin
                        n         = anchor;
                        p         = has_pos ? prev_link[pos] : tail_link;
                        was_empty = (tail_link == NIL);
                    end
                    slot_valid[x] = 1'b1;
                    prev_link[x]  = p;
                    next_link[x]  = n;
                    if (p != NIL) next_link[p] = x;
                    if (n != NIL) prev_link[n] = x;
                    if (kind == dlsl_pkg::KIND_INS_AFTER) begin
                        if (anchor == tail_link) tail_link = x;
                        if (was_empty || !has_pos) head_link = x;
                    end else begin
                        if (anchor == head_link) head_link = x;
                        if (was_empty || !has_pos) tail_link = x;
                    end
                    r.slot = x[dlsl_pkg::POS_W-1:0];
                end
            end
        end
        r.head  = (head_link == NIL) ? '0 : head_link[dlsl_pkg::POS_W-1:0];
        r.tail  = (tail_link == NIL) ? '0 : tail_link[dlsl_pkg::POS_W-1:0];
        r.empty = (head_link == NIL);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use = dlsl_pkg::SLOTS_IN_USE_RST;
            slot_valid   = '0;
            for (int i = 0; i < POOL; i++) begin
                prev_link[i] = NIL;
                next_link[i] = NIL;
            end
            head_link = NIL;
            tail_link = NIL;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result transaction with nothing expected:",
                                  " slot %0d status %0d"},
                                 $realtime, m_slot, m_status);
                end else begin
                    want = expected_results.pop_front();
                    if (m_slot !== want.slot || m_status !== want.status ||
                        m_head_slot !== want.head || m_tail_slot !== want.tail ||
                        m_list_empty !== want.empty) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result %0d mismatch: expected slot %0d status %0d",
                                      " head %0d tail %0d empty %0b, got slot %0d status %0d",
                                      " head %0d tail %0d empty %0b"},
                                     $realtime, results_checked, want.slot, want.status,
                                     want.head, want.tail, want.empty, m_slot, m_status,
                                     m_head_slot, m_tail_slot, m_list_empty);
                    end
                    results_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
                slots_in_use = cfg_data;
            if (s_valid && s_ready) begin
                want = apply_list_op(s_kind, s_has_position, s_position);
                if (want.status == dlsl_pkg::STAT_OK &&
                    (s_kind == dlsl_pkg::KIND_INS_AFTER ||
                     s_kind == dlsl_pkg::KIND_INS_BEFORE))
                    inserts_linked++;
                if (want.status == dlsl_pkg::STAT_FULL) full_reports++;
                if (want.status == dlsl_pkg::STAT_BAD) rejects++;
                expected_results.push_back(want);
            end
        end
        outstanding <= expected_results.size();
        occupied    <= slot_valid;
    end

endmodule

### bench/testbench.sv
// Top of the slot list bench: clock, reset, stimulus, result-side stalls and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dlsl_pkg::KIND_W-1:0] KIND_UNKNOWN = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 8;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic [dlsl_pkg::KIND_W-1:0]         s_kind         = '0;
    logic                                s_has_position = 1'b0;
    logic [dlsl_pkg::POS_W-1:0]          s_position     = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic [dlsl_pkg::POS_W-1:0]          m_slot;
    logic [dlsl_pkg::STATUS_W-1:0]       m_status;
    logic [dlsl_pkg::POS_W-1:0]          m_head_slot;
    logic [dlsl_pkg::POS_W-1:0]          m_tail_slot;
    logic                                m_list_empty;
    logic                                cfg_valid      = 1'b0;
    logic                                cfg_ready;
    logic [dlsl_pkg::CFG_W-1:0]          cfg_data       = '0;

    logic                                calm           = 1'b0;
    int                                  idle_cycles    = 0;
    int                                  cfg_writes     = 0;

    int                                  mismatches;
    int                                  outstanding;
    logic [dlsl_pkg::POOL_SLOTS_DEF-1:0] occupied;
    int                                  results_checked;
    int                                  inserts_linked;
    int                                  full_reports;
    int                                  rejects;

    doubly_linked_slot_list_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_has_position (s_has_position),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot         (m_slot),
        .m_status       (m_status),
        .m_head_slot    (m_head_slot),
        .m_tail_slot    (m_tail_slot),
        .m_list_empty   (m_list_empty),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    list_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_has_position  (s_has_position),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot          (m_slot),
        .m_status        (m_status),
        .m_head_slot     (m_head_slot),
        .m_tail_slot     (m_tail_slot),
        .m_list_empty    (m_list_empty),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .occupied        (occupied),
        .results_checked (results_checked),
        .inserts_linked  (inserts_linked),
        .full_reports    (full_reports),
        .rejects         (rejects)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Any accepted transaction on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [dlsl_pkg::POS_W-1:0] pick_in_use(
            logic [dlsl_pkg::POOL_SLOTS_DEF-1:0] occ);
        int candidates [$];
        int i;
        for (i = 0; i < dlsl_pkg::POOL_SLOTS_DEF; i++) begin
            if (occ[i]) candidates.push_back(i);
        end
        if (candidates.size() == 0)
            return dlsl_pkg::POS_W'($urandom_range(dlsl_pkg::POOL_SLOTS_DEF - 1));
        return dlsl_pkg::POS_W'(candidates[$urandom_range(candidates.size() - 1)]);
    endfunction

    task automatic send_op(input logic [dlsl_pkg::KIND_W-1:0] kind, input logic has_pos,
                           input logic [dlsl_pkg::POS_W-1:0] pos);
        int gap;
        gap = calm ? 0 : $urandom_range(12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_has_position <= has_pos;
        s_position     <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Holds the sender off until every result has come back and the block has settled.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_slots_in_use(input logic [dlsl_pkg::CFG_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly operations on slots that are in use, with some noise and bad positions.
    task automatic random_op(input int ins_pct);
        int                          r;
        logic [dlsl_pkg::KIND_W-1:0] kind;
        logic                        has_pos;
        logic [dlsl_pkg::POS_W-1:0]  pos;
        r = $urandom_range(99);
        if (r < 4) begin
            kind    = KIND_UNKNOWN;
            has_pos = 1'($urandom_range(1));
            pos     = dlsl_pkg::POS_W'($urandom_range(15));
        end else if (r < 4 + ins_pct) begin
            kind    = $urandom_range(1) ? dlsl_pkg::KIND_INS_BEFORE : dlsl_pkg::KIND_INS_AFTER;
            has_pos = ($urandom_range(3) != 0);
            pos     = ($urandom_range(9) != 0) ? pick_in_use(occupied)
                                               : dlsl_pkg::POS_W'($urandom_range(15));
        end else begin
            kind    = dlsl_pkg::KIND_DELETE;
            has_pos = ($urandom_range(19) != 0);
            pos     = ($urandom_range(9) != 0) ? pick_in_use(occupied)
                                               : dlsl_pkg::POS_W'($urandom_range(15));
        end
        send_op(kind, has_pos, pos);
    endtask

    task automatic run_phase(input logic [dlsl_pkg::CFG_W-1:0] setting, input int items,
                             input int ins_pct);
        drain_results();
        write_slots_in_use(setting);
        repeat (items) begin
            if ($urandom_range(19) == 0) calm <= ~calm;
            if ($urandom_range(59) == 0) drain_results();
            random_op(ins_pct);
        end
    endtask

    // Result side: a random stall before each result transaction.
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part on the reset setting of slots_in_use.
        send_op(dlsl_pkg::KIND_DELETE,     1'b0, 4'd0);   // delete with no position, empty list
        send_op(dlsl_pkg::KIND_INS_AFTER,  1'b0, 4'd0);   // first slot goes to the head
        send_op(dlsl_pkg::KIND_INS_BEFORE, 1'b0, 4'd0);   // no position: new tail
        send_op(dlsl_pkg::KIND_INS_AFTER,  1'b1, 4'd0);
        send_op(dlsl_pkg::KIND_INS_BEFORE, 1'b1, 4'd0);   // in front of the head
        send_op(dlsl_pkg::KIND_INS_AFTER,  1'b1, 4'd1);   // behind the tail
        send_op(dlsl_pkg::KIND_INS_BEFORE, 1'b1, 4'd15);  // next to a free slot
        send_op(dlsl_pkg::KIND_INS_AFTER,  1'b1, 4'd15);
        send_op(KIND_UNKNOWN,              1'b1, 4'd15);
        send_op(KIND_UNKNOWN,              1'b0, 4'd0);
        send_op(dlsl_pkg::KIND_DELETE,     1'b1, 4'd15);  // slot not in use
        send_op(dlsl_pkg::KIND_DELETE,     1'b1, 4'd2);   // middle of the list
        send_op(dlsl_pkg::KIND_DELETE,     1'b1, 4'd3);   // head
        send_op(dlsl_pkg::KIND_DELETE,     1'b1, 4'd4);   // tail
        send_op(dlsl_pkg::KIND_INS_BEFORE, 1'b1, 4'd0);
        send_op(dlsl_pkg::KIND_DELETE,     1'b1, 4'd0);
        send_op(dlsl_pkg::KIND_DELETE,     1'b1, 4'd1);
        send_op(dlsl_pkg::KIND_DELETE,     1'b1, 4'd2);   // list is empty again
        send_op(dlsl_pkg::KIND_INS_AFTER,  1'b1, 4'd0);

        // A one-slot pool fills at once; a free position is reported before a full pool.
        drain_results();
        write_slots_in_use(5'd1);
        send_op(dlsl_pkg::KIND_INS_BEFORE, 1'b0, 4'd0);
        send_op(dlsl_pkg::KIND_INS_AFTER,  1'b1, 4'd0);
        send_op(dlsl_pkg::KIND_INS_AFTER,  1'b1, 4'd9);
        send_op(dlsl_pkg::KIND_DELETE,     1'b1, 4'd0);

        // A zero setting reports the pool full for an insert with no position.
        drain_results();
        write_slots_in_use(5'd0);
        send_op(dlsl_pkg::KIND_INS_AFTER,  1'b0, 4'd0);

        // Random part: fill the whole pool, then shrink it with slots still linked above.
        run_phase(5'd16, 70, 75);
        run_phase(5'd4,  70, 45);
        run_phase(5'd31, 70, 60);
        run_phase(5'd0,  40, 40);
        run_phase(5'd1,  60, 50);
        run_phase(5'd9,  70, 55);
        run_phase(5'd16, 80, 70);
        run_phase(5'd2,  60, 45);
        run_phase(5'd12, 70, 50);

        drain_results();
        $display("Checked %0d list operations across %0d slots_in_use writes, 0 and 31 included.",
                 results_checked, cfg_writes);
        $display("%0d inserts linked a slot, %0d met a full pool, %0d were rejected.",
                 inserts_linked, full_reports, rejects);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
rtl/dlsl_pkg.sv
rtl/dlsl_ram.sv
rtl/dlsl_ctrl.sv
rtl/dlsl_dp.sv
rtl/doubly_linked_slot_list_unit.sv
bench/list_checker.sv
bench/testbench.sv
